### src/ipfht_pkg.sv
// Shared types and constants for the IP fragment hole tracker.
package ipfht_pkg;

    localparam logic [15:0] HOLE_END = 16'hFFFF;

    // Input command codes
    localparam logic [1:0] CMD_FRAG  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_NOT_FRAG = 3'd0;
    localparam logic [2:0] ST_WAITING  = 3'd1;
    localparam logic [2:0] ST_COMPLETE = 3'd2;
    localparam logic [2:0] ST_NO_ROOM  = 3'd3;
    localparam logic [2:0] ST_FREED    = 3'd4;
    localparam logic [2:0] ST_IDLE     = 3'd5;
    localparam logic [2:0] ST_RANGE    = 3'd6;

    // One hole descriptor
    typedef struct packed {
        logic [15:0] first;
        logic [15:0] last;
    } hole_t;

    // Request to the hole unit: trim one hole against the fragment
    typedef struct packed {
        logic [15:0] ff;
        logic [15:0] fl;
        logic        mf;
        hole_t       hole;
    } trim_req_t;

    // Result of trimming one hole
    typedef struct packed {
        logic  overlap;
        logic  split;
        logic  keep;
        hole_t head;
        hole_t tail;
    } trim_rsp_t;

endpackage

### src/ip_fragment_hole_tracker_top.sv
// Top level of the IP fragment hole tracker.
// One item at a time. A fragment takes a key scan over the contexts and, when no
// live context matches, a search for a free one. It then takes a spare/split scan
// over the hole slots and a trim pass over them through the one shared hole unit,
// then a state to report. A tick or flush scans the contexts and frees the first one
// that is expired (tick) or valid (flush), if any. A pass-through, range-error or
// unused-command item is answered from idle. The block is not ready while an item is
// at work; the result sits in an output register and the next item is taken once the
// result has been accepted. No clearing pass after reset: per-entry valid bits sit in
// flip-flops.
module ip_fragment_hole_tracker_top #(
    parameter int CONTEXTS  = 4,
    parameter int MAX_HOLES = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_src_addr,
    input  logic [31:0] s_dst_addr,
    input  logic [15:0] s_ident,
    input  logic [7:0]  s_protocol,
    input  logic [12:0] s_frag_offset,
    input  logic [15:0] s_payload_len,
    input  logic        s_more_fragments,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [1:0]  m_context_index,
    output logic [15:0] m_reasm_bytes,
    output logic [3:0]  m_holes_left
);
    import ipfht_pkg::*;

    localparam int CW = (CONTEXTS > 1) ? $clog2(CONTEXTS) : 1;
    localparam int HW = $clog2(MAX_HOLES);
    localparam int SLOTS = CONTEXTS * MAX_HOLES;
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MATCH = 6'b000010,
        S_ALLOC = 6'b000100,
        S_SCAN  = 6'b001000,
        S_TRIM  = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0] timeout_reg;
    logic [31:0] tick_reg;

    logic [CONTEXTS-1:0] ctx_valid_reg;
    logic [31:0] ctx_src_reg   [CONTEXTS];
    logic [31:0] ctx_dst_reg   [CONTEXTS];
    logic [15:0] ctx_ident_reg [CONTEXTS];
    logic [7:0]  ctx_prot_reg  [CONTEXTS];
    logic [31:0] ctx_start_reg [CONTEXTS];
    logic [15:0] ctx_len_reg   [CONTEXTS];

    logic [SLOTS-1:0] hole_valid_reg;
    hole_t hole_mem [SLOTS];

    // Latched item
    logic [1:0]  cmd_reg;
    logic [31:0] src_reg, dst_reg;
    logic [15:0] ident_reg;
    logic [7:0]  prot_reg;
    logic [15:0] ff_reg, fl_reg, end_reg;
    logic        mf_reg;

    logic [CW-1:0] ci_reg;
    logic [HW:0]   k_reg;
    logic          need_split_reg, have_spare_reg;
    logic [HW-1:0] spare_reg;

    logic        m_valid_reg;
    logic [2:0]  st_reg;
    logic [1:0]  oci_reg;
    logic [15:0] tot_reg;
    logic [3:0]  hl_reg;

    assign s_ready = (state_reg == S_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_status = st_reg;
    assign m_context_index = oci_reg;
    assign m_reasm_bytes = tot_reg;
    assign m_holes_left = hl_reg;

    // Current context and slot
    logic [HW-1:0] kk;
    logic [SW-1:0] slot;
    logic          expired;
    logic [16:0]   end_sum;
    assign kk = k_reg[HW-1:0];
    assign slot = SW'(ci_reg * MAX_HOLES + kk);
    assign expired = (tick_reg - ctx_start_reg[ci_reg]) >= {16'd0, timeout_reg};
    assign end_sum = {1'b0, s_frag_offset, 3'b000} + {1'b0, s_payload_len};

    trim_req_t req;
    trim_rsp_t rsp;
    assign req.ff = ff_reg;
    assign req.fl = fl_reg;
    assign req.mf = mf_reg;
    assign req.hole = hole_mem[slot];

    ipfht_hole_unit u_hole (.req(req), .rsp(rsp));

    logic last_ctx;
    logic last_k;
    assign last_ctx = (ci_reg == CW'(CONTEXTS - 1));
    assign last_k = (k_reg == (HW+1)'(MAX_HOLES - 1));

    // Population count of the current context's valid bits
    logic [HW:0] hole_cnt;
    always_comb begin
        hole_cnt = '0;
        for (int i = 0; i < MAX_HOLES; i++)
            hole_cnt = hole_cnt + (HW+1)'(hole_valid_reg[SW'(ci_reg * MAX_HOLES + i)]);
    end

    // Main sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            timeout_reg <= 16'd30;
            tick_reg <= '0;
            ctx_valid_reg <= '0;
            hole_valid_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
            if (m_valid_reg && m_ready)
                m_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        cmd_reg <= s_command;
                        src_reg <= s_src_addr;
                        dst_reg <= s_dst_addr;
                        ident_reg <= s_ident;
                        prot_reg <= s_protocol;
                        ff_reg <= {s_frag_offset, 3'b000};
                        fl_reg <= end_sum[15:0] - 16'd1;
                        end_reg <= end_sum[15:0];
                        mf_reg <= s_more_fragments;
                        ci_reg <= '0;
                        oci_reg <= '0;
                        tot_reg <= '0;
                        hl_reg <= '0;
                        if (s_command == CMD_TICK)
                            tick_reg <= tick_reg + 32'd1;
                        if (s_command == CMD_FRAG) begin
                            if (s_frag_offset == '0 && !s_more_fragments) begin
                                st_reg <= ST_NOT_FRAG;
                                m_valid_reg <= 1'b1;
                            end else if (s_payload_len == '0 || end_sum[16]) begin
                                st_reg <= ST_RANGE;
                                m_valid_reg <= 1'b1;
                            end else begin
                                state_reg <= S_MATCH;
                            end
                        end else if (s_command inside {CMD_TICK, CMD_FLUSH}) begin
                            state_reg <= S_MATCH;
                        end else begin
                            st_reg <= ST_IDLE;
                            m_valid_reg <= 1'b1;
                        end
                    end
                end
                S_MATCH: begin
                    // One context per cycle
                    if (cmd_reg == CMD_FRAG) begin
                        if (ctx_valid_reg[ci_reg] && ctx_src_reg[ci_reg] == src_reg
                            && ctx_dst_reg[ci_reg] == dst_reg
                            && ctx_ident_reg[ci_reg] == ident_reg
                            && ctx_prot_reg[ci_reg] == prot_reg && !expired) begin
                            k_reg <= '0;
                            have_spare_reg <= 1'b0;
                            need_split_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end else if (last_ctx) begin
                            ci_reg <= '0;
                            state_reg <= S_ALLOC;
                        end else begin
                            ci_reg <= ci_reg + CW'(1);
                        end
                    end else begin
                        if (ctx_valid_reg[ci_reg]
                            && (cmd_reg == CMD_FLUSH || expired)) begin
                            ctx_valid_reg[ci_reg] <= 1'b0;
                            for (int i = 0; i < MAX_HOLES; i++)
                                hole_valid_reg[SW'(ci_reg * MAX_HOLES + i)] <= 1'b0;
                            st_reg <= ST_FREED;
                            oci_reg <= 2'(ci_reg);
                            m_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end else if (last_ctx) begin
                            st_reg <= ST_IDLE;
                            m_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end else begin
                            ci_reg <= ci_reg + CW'(1);
                        end
                    end
                end
                S_ALLOC: begin
                    // Lowest free context, one per cycle
                    if (!ctx_valid_reg[ci_reg]) begin
                        ctx_valid_reg[ci_reg] <= 1'b1;
                        ctx_src_reg[ci_reg] <= src_reg;
                        ctx_dst_reg[ci_reg] <= dst_reg;
                        ctx_ident_reg[ci_reg] <= ident_reg;
                        ctx_prot_reg[ci_reg] <= prot_reg;
                        ctx_start_reg[ci_reg] <= tick_reg;
                        ctx_len_reg[ci_reg] <= '0;
                        for (int i = 0; i < MAX_HOLES; i++)
                            hole_valid_reg[SW'(ci_reg * MAX_HOLES + i)] <= (i == 0);
                        hole_mem[SW'(ci_reg * MAX_HOLES)] <= '{first: 16'd0, last: HOLE_END};
                        k_reg <= '0;
                        have_spare_reg <= 1'b0;
                        need_split_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end else if (last_ctx) begin
                        st_reg <= ST_NO_ROOM;
                        oci_reg <= '0;
                        m_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end else begin
                        ci_reg <= ci_reg + CW'(1);
                    end
                end
                S_SCAN: begin
                    // Find a spare slot and whether a split is needed
                    if (!hole_valid_reg[slot]) begin
                        if (!have_spare_reg) begin
                            spare_reg <= kk;
                            have_spare_reg <= 1'b1;
                        end
                    end else if (mf_reg && ff_reg > req.hole.first
                                 && fl_reg < req.hole.last) begin
                        need_split_reg <= 1'b1;
                    end
                    if (last_k) begin
                        k_reg <= '0;
                        if ((need_split_reg || (hole_valid_reg[slot] && mf_reg
                             && ff_reg > req.hole.first && fl_reg < req.hole.last))
                            && !(have_spare_reg || !hole_valid_reg[slot])) begin
                            st_reg <= ST_NO_ROOM;
                            oci_reg <= 2'(ci_reg);
                            m_valid_reg <= 1'b1;
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_TRIM;
                        end
                    end else begin
                        k_reg <= k_reg + (HW+1)'(1);
                    end
                end
                S_TRIM: begin
                    // Trim one hole per cycle; split tail goes to the spare slot
                    if (hole_valid_reg[slot]) begin
                        if (rsp.overlap) begin
                            if (rsp.split) begin
                                hole_mem[slot] <= rsp.head;
                                hole_mem[SW'(ci_reg * MAX_HOLES + spare_reg)] <= rsp.tail;
                                hole_valid_reg[SW'(ci_reg * MAX_HOLES + spare_reg)] <= 1'b1;
                            end else if (rsp.keep) begin
                                hole_mem[slot] <= rsp.head;
                            end else begin
                                hole_valid_reg[slot] <= 1'b0;
                            end
                        end
                    end
                    if (last_k) begin
                        if (!mf_reg)
                            ctx_len_reg[ci_reg] <= end_reg;
                        state_reg <= S_DONE;
                    end else begin
                        k_reg <= k_reg + (HW+1)'(1);
                    end
                end
                S_DONE: begin
                    // Count the holes left and report
                    oci_reg <= 2'(ci_reg);
                    m_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                    if (hole_cnt == '0) begin
                        st_reg <= ST_COMPLETE;
                        tot_reg <= ctx_len_reg[ci_reg];
                        ctx_valid_reg[ci_reg] <= 1'b0;
                    end else begin
                        st_reg <= ST_WAITING;
                        hl_reg <= 4'(hole_cnt);
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

### src/ipfht_hole_unit.sv
// Shared hole trim unit: compares one hole with the fragment and gives the new hole(s).
module ipfht_hole_unit (
    input  ipfht_pkg::trim_req_t req,
    output ipfht_pkg::trim_rsp_t rsp
);
    import ipfht_pkg::*;

    logic keep_head;
    logic keep_tail;

    // Overlap and what is left on each side
    always_comb begin
        keep_head = req.ff > req.hole.first;
        keep_tail = req.mf && (req.fl < req.hole.last);
        rsp.overlap = !((req.ff > req.hole.last) || (req.fl < req.hole.first));
        rsp.split = keep_head && keep_tail;
        rsp.keep = keep_head || keep_tail;
        rsp.head.first = keep_head ? req.hole.first : req.fl + 16'd1;
        rsp.head.last = keep_head ? req.ff - 16'd1 : req.hole.last;
        rsp.tail.first = req.fl + 16'd1;
        rsp.tail.last = req.hole.last;
    end

endmodule

### src/ipfht_checker.sv
// Port-level checks for the IP fragment hole tracker, bound to the top level.
module ipfht_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [15:0] m_reasm_bytes,
    input logic [3:0]  m_holes_left
);
    import ipfht_pkg::*;

    // No new item while a result waits
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("ready while result pending");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status))
        else $error("result dropped");

    // Reassembled length only on completion
    a_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != ST_COMPLETE |-> m_reasm_bytes == 16'd0)
        else $error("stray reassembled length");

    // Waiting reports at least one hole
    a_holes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_WAITING |-> m_holes_left != 4'd0)
        else $error("waiting with no holes");

endmodule

bind ip_fragment_hole_tracker_top ipfht_checker u_ipfht_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
    .m_reasm_bytes(m_reasm_bytes), .m_holes_left(m_holes_left)
);
